FILE: hw/rtl/krt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package krt_pkg;

  // Command codes carried in the command field of an input item
  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RTT_NOISE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

  // Register reset values: 25.0, 5.0 and 100.0 with 16 fractional bits
  localparam logic [CFG_DATA_W-1:0] RTT_NOISE_RST   = 32'd1638400;
  localparam logic [CFG_DATA_W-1:0] DRIFT_NOISE_RST = 32'd327680;
  localparam logic [CFG_DATA_W-1:0] MEAS_NOISE_RST  = 32'd6553600;

  // Payload field widths
  localparam int unsigned RTT_IN_W = 36;
  localparam int unsigned EST_W    = 48;
  localparam int unsigned VAR_W    = 47;

  // Covariance loaded on restart, in whole units
  localparam int unsigned RESTART_COV_LEVEL = 400;
  localparam int unsigned RESTART_COV_DRIFT = 100;

  // Multiplier digit: bits of the second operand consumed per cycle
  localparam int unsigned MUL_DIGIT = 16;

  // Status returned by the multi-cycle arithmetic units
  typedef struct packed {
    logic done;
    logic sat;
  } krt_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/krt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface krt_in_if import krt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [RTT_IN_W-1:0] rtt_value;

  modport source (output valid, output command, output rtt_value, input ready);
  modport sink   (input valid, input command, input rtt_value, output ready);
endinterface

interface krt_out_if import krt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] rtt_estimate;
  logic signed [EST_W-1:0] drift_estimate;
  logic [VAR_W-1:0]        level_var;
  logic                    saturated;

  modport source (output valid, output rtt_estimate, output drift_estimate,
                  output level_var, output saturated, input ready);
  modport sink   (input valid, input rtt_estimate, input drift_estimate,
                  input level_var, input saturated, output ready);
endinterface

interface krt_cfg_if import krt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/kalman_rtt_tracker_top.sv
// Two-state (level plus drift) Kalman tracker for round-trip time.
// Channels: meas_i takes one item per command (restart or measurement, rtt in
// fixed point with FRAC_BITS fraction); res_o returns one item per command with
// the new level, drift, level variance and a saturation flag. cfg_i writes the
// three noise registers (index 0 rtt noise, 1 drift noise, 2 measurement noise;
// other indexes are ignored) and is always ready; write it only while idle.
// Sequencing: a restart goes from acceptance through S_EMIT into the output
// register. A measurement runs on one saturating adder, one digit-serial
// multiplier and one restoring divider under a sequencer: the two gain
// divisions, the five multiplies and the adds, then S_EMIT registers the
// result. The divider produces one quotient bit per cycle. When the innovation
// variance is not positive the divisions are skipped. meas_i is ready only
// between items, from the edge at which a result is registered.
// Reset: registers take their reset values, state is level 0, drift 0, and
// covariance 400, 0, 100; no result is pending.
// Stall: a result waits in the output register while res_o is not ready; the
// next item may be accepted meanwhile and its result waits until the slot frees.
`timescale 1ns / 1ps
`default_nettype none

module kalman_rtt_tracker_top import krt_pkg::*; #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned STATE_WIDTH = 48
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  krt_cfg_if.sink   cfg_i,
  krt_in_if.sink    meas_i,
  krt_out_if.source res_o
);

  localparam int unsigned W  = STATE_WIDTH;
  localparam int unsigned UW = ((W > 40) ? W : 40) + 1;

  localparam logic [W-1:0]  VMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  VMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic [UW-1:0] VMAX_U = UW'(VMAX);
  localparam logic [W-1:0]  ONE    = W'(1) << FRAC_BITS;

  localparam logic [UW-1:0] C400_U    = UW'(RESTART_COV_LEVEL) << FRAC_BITS;
  localparam logic [UW-1:0] C100_U    = UW'(RESTART_COV_DRIFT) << FRAC_BITS;
  localparam logic          C400_CLIP = C400_U > VMAX_U;
  localparam logic          C100_CLIP = C100_U > VMAX_U;
  localparam logic [W-1:0]  C400_V    = C400_CLIP ? VMAX : C400_U[W-1:0];
  localparam logic [W-1:0]  C100_V    = C100_CLIP ? VMAX : C100_U[W-1:0];

  // Multiply steps, in order
  localparam logic [2:0] MS_LEVEL = 3'd0;
  localparam logic [2:0] MS_DRIFT = 3'd1;
  localparam logic [2:0] MS_COV00 = 3'd2;
  localparam logic [2:0] MS_COV01 = 3'd3;
  localparam logic [2:0] MS_COV11 = 3'd4;
  // Divide steps
  localparam logic DS_K0 = 1'b0;
  localparam logic DS_K1 = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_PRED, S_PP_A, S_PP_B, S_PP_C, S_PP_D, S_PP01, S_PP11,
    S_INNOV, S_ERR, S_DIV_GO, S_DIV_WAIT, S_MUL_GO, S_MUL_WAIT, S_ONE_K0, S_EMIT
  } state_e;

  // Clamp an unsigned value to the top of the state range; bit W flags a clip.
  function automatic logic [W:0] clamp_u(input logic [UW-1:0] v);
    logic [W:0] r;
    if (v > VMAX_U) begin
      r = {1'b1, VMAX};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  // Raise a variance to at least one LSB.
  function automatic logic [W-1:0] floor1(input logic [W-1:0] v);
    logic [W-1:0] r;
    if (v[W-1] || (v == '0)) begin
      r = W'(1);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Configuration registers
  logic [CFG_DATA_W-1:0] rtt_noise_q, drift_noise_q, meas_noise_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtt_noise_q   <= RTT_NOISE_RST;
      drift_noise_q <= DRIFT_NOISE_RST;
      meas_noise_q  <= MEAS_NOISE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_RTT_NOISE:   rtt_noise_q   <= cfg_i.data;
        CFG_DRIFT_NOISE: drift_noise_q <= cfg_i.data;
        CFG_MEAS_NOISE:  meas_noise_q  <= cfg_i.data;
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  state_e       state_q;
  logic [2:0]   mstep_q;
  logic         dstep_q;
  logic         sat_q;

  logic [W-1:0] level_q, drift_q, c00_q, c01_q, c11_q;
  logic [W-1:0] meas_q, pred_q, t_q, pp00_q, pp01_q, pp11_q, s_q, e_q, k0_q, k1_q;

  logic                    res_valid_q;
  logic signed [EST_W-1:0] res_rtt_q, res_drift_q;
  logic [VAR_W-1:0]        res_var_q;
  logic                    res_sat_q;

  logic [W:0]   meas_cl, qr_cl, qd_cl, rn_cl;

  always_comb begin
    meas_cl = clamp_u(UW'(meas_i.rtt_value));
    qr_cl   = clamp_u(UW'(rtt_noise_q));
    qd_cl   = clamp_u(UW'(drift_noise_q));
    rn_cl   = clamp_u(UW'(meas_noise_q));
  end

  // Shared arithmetic units
  logic         mul_start, div_start;
  logic [W-1:0] mul_a, mul_b, mul_res, div_num, div_res;
  krt_sts_t     mul_sts, div_sts;

  assign mul_start = (state_q == S_MUL_GO);
  assign div_start = (state_q == S_DIV_GO);
  assign div_num   = (dstep_q == DS_K1) ? pp01_q : pp00_q;

  always_comb begin
    case (mstep_q)
      MS_LEVEL: begin mul_a = k0_q; mul_b = e_q;    end
      MS_DRIFT: begin mul_a = k1_q; mul_b = e_q;    end
      MS_COV00: begin mul_a = t_q;  mul_b = pp00_q; end
      MS_COV01: begin mul_a = t_q;  mul_b = pp01_q; end
      default:  begin mul_a = k1_q; mul_b = pp01_q; end
    endcase
  end

  krt_mul #(
    .STATE_WIDTH (STATE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .res_o   (mul_res),
    .sts_o   (mul_sts)
  );

  krt_div #(
    .STATE_WIDTH (STATE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (s_q),
    .res_o   (div_res),
    .sts_o   (div_sts)
  );

  // Saturating adder shared by every add and subtract
  logic [W-1:0] alu_a, alu_b, alu_res;
  logic         alu_sub, alu_en, alu_clip;
  logic [W:0]   alu_sum;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    alu_en  = 1'b1;
    case (state_q)
      S_PRED:   begin alu_a = level_q; alu_b = drift_q;         end
      S_PP_A:   begin alu_a = c01_q;   alu_b = c01_q;           end
      S_PP_B:   begin alu_a = c00_q;   alu_b = t_q;             end
      S_PP_C:   begin alu_a = t_q;     alu_b = c11_q;           end
      S_PP_D:   begin alu_a = t_q;     alu_b = qr_cl[W-1:0];    end
      S_PP01:   begin alu_a = c01_q;   alu_b = c11_q;           end
      S_PP11:   begin alu_a = c11_q;   alu_b = qd_cl[W-1:0];    end
      S_INNOV:  begin alu_a = pp00_q;  alu_b = rn_cl[W-1:0];    end
      S_ERR:    begin alu_a = meas_q;  alu_b = pred_q; alu_sub = 1'b1; end
      S_ONE_K0: begin alu_a = ONE;     alu_b = k0_q;   alu_sub = 1'b1; end
      S_MUL_WAIT: begin
        alu_en = mul_sts.done;
        alu_b  = mul_res;
        case (mstep_q)
          MS_LEVEL: alu_a = pred_q;
          MS_DRIFT: alu_a = drift_q;
          MS_COV11: begin alu_a = pp11_q; alu_sub = 1'b1; end
          default:  begin alu_b = '0; alu_en = 1'b0; end
        endcase
      end
      default: begin
        alu_en = 1'b0;
      end
    endcase
    alu_sum  = alu_sub ? ({alu_a[W-1], alu_a} - {alu_b[W-1], alu_b})
                       : ({alu_a[W-1], alu_a} + {alu_b[W-1], alu_b});
    alu_clip = alu_sum[W] ^ alu_sum[W-1];
    alu_res  = alu_clip ? (alu_sum[W] ? VMIN : VMAX) : alu_sum[W-1:0];
  end

  // Collect a clip from the adder or from a finishing multiply or divide
  logic sat_set, res_load;

  assign sat_set  = (alu_en & alu_clip) |
                    ((state_q == S_DIV_WAIT) & div_sts.done & div_sts.sat) |
                    ((state_q == S_MUL_WAIT) & mul_sts.done & mul_sts.sat);
  assign res_load = (state_q == S_EMIT) && (!res_valid_q || res_o.ready);

  assign meas_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mstep_q     <= MS_LEVEL;
      dstep_q     <= DS_K0;
      sat_q       <= 1'b0;
      level_q     <= '0;
      drift_q     <= '0;
      c00_q       <= C400_V;
      c01_q       <= '0;
      c11_q       <= C100_V;
      meas_q      <= '0;
      pred_q      <= '0;
      t_q         <= '0;
      pp00_q      <= '0;
      pp01_q      <= '0;
      pp11_q      <= '0;
      s_q         <= '0;
      e_q         <= '0;
      k0_q        <= '0;
      k1_q        <= '0;
      res_valid_q <= 1'b0;
      res_rtt_q   <= '0;
      res_drift_q <= '0;
      res_var_q   <= '0;
      res_sat_q   <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      if (sat_set) begin
        sat_q <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (meas_i.valid) begin
            if (meas_i.command == CMD_RESTART) begin
              level_q <= meas_cl[W-1:0];
              drift_q <= '0;
              c00_q   <= C400_V;
              c01_q   <= '0;
              c11_q   <= C100_V;
              sat_q   <= meas_cl[W] | C400_CLIP | C100_CLIP;
              state_q <= S_EMIT;
            end else begin
              meas_q  <= meas_cl[W-1:0];
              sat_q   <= meas_cl[W] | qr_cl[W] | qd_cl[W] | rn_cl[W];
              state_q <= S_PRED;
            end
          end
        end
        S_PRED:  begin pred_q <= alu_res; state_q <= S_PP_A;  end
        S_PP_A:  begin t_q    <= alu_res; state_q <= S_PP_B;  end
        S_PP_B:  begin t_q    <= alu_res; state_q <= S_PP_C;  end
        S_PP_C:  begin t_q    <= alu_res; state_q <= S_PP_D;  end
        S_PP_D:  begin pp00_q <= alu_res; state_q <= S_PP01;  end
        S_PP01:  begin pp01_q <= alu_res; state_q <= S_PP11;  end
        S_PP11:  begin pp11_q <= alu_res; state_q <= S_INNOV; end
        S_INNOV: begin s_q    <= alu_res; state_q <= S_ERR;   end
        S_ERR: begin
          e_q     <= alu_res;
          k0_q    <= '0;
          k1_q    <= '0;
          dstep_q <= DS_K0;
          mstep_q <= MS_LEVEL;
          // gains stay zero unless the innovation variance is positive
          if (!s_q[W-1] && (s_q != '0)) begin
            state_q <= S_DIV_GO;
          end else begin
            state_q <= S_MUL_GO;
          end
        end
        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_sts.done) begin
            if (dstep_q == DS_K0) begin
              k0_q    <= div_res;
              dstep_q <= DS_K1;
              state_q <= S_DIV_GO;
            end else begin
              k1_q    <= div_res;
              state_q <= S_MUL_GO;
            end
          end
        end
        S_MUL_GO: begin
          state_q <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mul_sts.done) begin
            case (mstep_q)
              MS_LEVEL: begin
                level_q <= alu_res;
                mstep_q <= MS_DRIFT;
                state_q <= S_MUL_GO;
              end
              MS_DRIFT: begin
                drift_q <= alu_res;
                mstep_q <= MS_COV00;
                state_q <= S_ONE_K0;
              end
              MS_COV00: begin
                c00_q   <= floor1(mul_res);
                mstep_q <= MS_COV01;
                state_q <= S_MUL_GO;
              end
              MS_COV01: begin
                c01_q   <= mul_res;
                mstep_q <= MS_COV11;
                state_q <= S_MUL_GO;
              end
              default: begin
                c11_q   <= floor1(alu_res);
                state_q <= S_EMIT;
              end
            endcase
          end
        end
        S_ONE_K0: begin
          t_q     <= alu_res;
          state_q <= S_MUL_GO;
        end
        S_EMIT: begin
          // hold until the output slot is free
          if (res_load) begin
            res_rtt_q   <= EST_W'($signed(level_q));
            res_drift_q <= EST_W'($signed(drift_q));
            res_var_q   <= VAR_W'($signed(c00_q));
            res_sat_q   <= sat_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.rtt_estimate   = res_rtt_q;
  assign res_o.drift_estimate = res_drift_q;
  assign res_o.level_var      = res_var_q;
  assign res_o.saturated      = res_sat_q;

endmodule

`default_nettype wire

FILE: hw/rtl/krt_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed fixed-point multiply, (a * b) >> FRAC_BITS truncated toward zero,
// saturated to the state range. One MUL_DIGIT-bit digit of |b| per cycle.
module krt_mul import krt_pkg::*; #(
  parameter int unsigned STATE_WIDTH = 48,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [STATE_WIDTH-1:0] a_i,
  input  wire logic [STATE_WIDTH-1:0] b_i,
  output      logic [STATE_WIDTH-1:0] res_o,
  output      krt_sts_t               sts_o
);

  localparam int unsigned W     = STATE_WIDTH;
  localparam int unsigned ND    = (W + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int unsigned YW    = ND * MUL_DIGIT;
  localparam int unsigned PW    = W + YW;
  localparam int unsigned CNT_W = $clog2(ND);
  localparam logic [W-1:0] VMAX_U = {1'b0, {(W-1){1'b1}}};

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} phase_e;

  phase_e                 phase_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [W-1:0]           x_q;
  logic [PW-1:0]          p_q;
  logic                   neg_q;
  logic [W-1:0]           res_q;
  logic                   done_q;
  logic                   sat_q;

  logic [W-1:0]           a_mag, b_mag;
  logic [MUL_DIGIT-1:0]   digit;
  logic [W+MUL_DIGIT-1:0] part, acc;
  logic [PW-1:0]          mag, lim, clip_mag;
  logic                   over;
  logic [W-1:0]           mag_w;

  always_comb begin
    a_mag    = a_i[W-1] ? ((~a_i) + W'(1)) : a_i;
    b_mag    = b_i[W-1] ? ((~b_i) + W'(1)) : b_i;
    digit    = p_q[MUL_DIGIT-1:0];
    part     = x_q * digit;
    acc      = (W+MUL_DIGIT)'(p_q[PW-1:YW]) + part;
    mag      = p_q >> FRAC_BITS;
    lim      = PW'(VMAX_U) + PW'(neg_q);
    over     = mag > lim;
    clip_mag = over ? lim : mag;
    mag_w    = clip_mag[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= M_IDLE;
      cnt_q   <= '0;
      x_q     <= '0;
      p_q     <= '0;
      neg_q   <= 1'b0;
      res_q   <= '0;
      done_q  <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (phase_q)
        M_IDLE: begin
          if (start_i) begin
            x_q     <= a_mag;
            p_q     <= {{W{1'b0}}, YW'(b_mag)};
            neg_q   <= a_i[W-1] ^ b_i[W-1];
            cnt_q   <= '0;
            phase_q <= M_RUN;
          end
        end
        M_RUN: begin
          // add digit product to the upper half, shift one digit down
          p_q   <= {acc, p_q[YW-1:MUL_DIGIT]};
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(ND - 1)) begin
            phase_q <= M_FIN;
          end
        end
        M_FIN: begin
          res_q   <= neg_q ? ((~mag_w) + W'(1)) : mag_w;
          sat_q   <= over;
          done_q  <= 1'b1;
          phase_q <= M_IDLE;
        end
        default: begin
          phase_q <= M_IDLE;
        end
      endcase
    end
  end

  assign res_o      = res_q;
  assign sts_o.done = done_q;
  assign sts_o.sat  = sat_q;

endmodule

`default_nettype wire

FILE: hw/rtl/krt_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed fixed-point divide, (num << FRAC_BITS) / den for den > 0, truncated
// toward zero and saturated to the state range. Restoring, one bit per cycle.
module krt_div import krt_pkg::*; #(
  parameter int unsigned STATE_WIDTH = 48,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [STATE_WIDTH-1:0] num_i,
  input  wire logic [STATE_WIDTH-1:0] den_i,
  output      logic [STATE_WIDTH-1:0] res_o,
  output      krt_sts_t               sts_o
);

  localparam int unsigned W     = STATE_WIDTH;
  localparam int unsigned NW    = W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NW);
  localparam logic [W-1:0] VMAX_U = {1'b0, {(W-1){1'b1}}};

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} phase_e;

  phase_e           phase_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]     rem_q;
  logic [W-1:0]     den_q;
  logic [NW-1:0]    quo_q;
  logic             neg_q;
  logic [W-1:0]     res_q;
  logic             done_q;
  logic             sat_q;

  logic [W-1:0]     num_mag;
  logic [W:0]       trial, diff;
  logic             ge;
  logic [NW-1:0]    lim, clip_mag;
  logic             over;
  logic [W-1:0]     mag_w;

  always_comb begin
    num_mag  = num_i[W-1] ? ((~num_i) + W'(1)) : num_i;
    trial    = {rem_q, quo_q[NW-1]};
    diff     = trial - {1'b0, den_q};
    ge       = trial >= {1'b0, den_q};
    lim      = NW'(VMAX_U) + NW'(neg_q);
    over     = quo_q > lim;
    clip_mag = over ? lim : quo_q;
    mag_w    = clip_mag[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= D_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      den_q   <= '0;
      quo_q   <= '0;
      neg_q   <= 1'b0;
      res_q   <= '0;
      done_q  <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (phase_q)
        D_IDLE: begin
          if (start_i) begin
            quo_q   <= {num_mag, {FRAC_BITS{1'b0}}};
            rem_q   <= '0;
            den_q   <= den_i;
            neg_q   <= num_i[W-1];
            cnt_q   <= '0;
            phase_q <= D_RUN;
          end
        end
        D_RUN: begin
          // remainder stays below den, so it keeps W bits
          rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
          quo_q <= {quo_q[NW-2:0], ge};
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(NW - 1)) begin
            phase_q <= D_FIN;
          end
        end
        D_FIN: begin
          res_q   <= neg_q ? ((~mag_w) + W'(1)) : mag_w;
          sat_q   <= over;
          done_q  <= 1'b1;
          phase_q <= D_IDLE;
        end
        default: begin
          phase_q <= D_IDLE;
        end
      endcase
    end
  end

  assign res_o      = res_q;
  assign sts_o.done = done_q;
  assign sts_o.sat  = sat_q;

endmodule

`default_nettype wire

FILE: tb/kalman_rtt_tracker_checker.sv
`timescale 1ns / 1ps

module kalman_rtt_tracker_checker import krt_pkg::*; #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned STATE_WIDTH = 48
) (
  input  logic clk_i,
  input  logic rst_ni,
  krt_cfg_if   cfg_i,
  krt_in_if    meas_i,
  krt_out_if   res_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam longint VMAX   = (longint'(1) <<< (STATE_WIDTH - 1)) - 1;
  localparam longint VMIN   = -VMAX - 1;
  localparam longint ONE_FX = longint'(1) <<< FRAC_BITS;

  typedef struct packed {
    logic [EST_W-1:0] rtt_est;
    logic [EST_W-1:0] drift_est;
    logic [VAR_W-1:0] rtt_var;
    logic             sat;
  } tracker_out_t;

  // Filter state and noise registers as the block should hold them
  logic [CFG_DATA_W-1:0] q_rtt;
  logic [CFG_DATA_W-1:0] q_drift;
  logic [CFG_DATA_W-1:0] r_meas;
  longint                lvl_fx;
  longint                drift_fx;
  longint                p_ll;
  longint                p_ld;
  longint                p_dd;
  bit                    clip_flag;

  tracker_out_t estimate_q[$];
  tracker_out_t want;
  int           mismatches;

  function automatic longint clamp_w(longint v);
    if (v > VMAX) begin
      clip_flag = 1'b1;
      return VMAX;
    end
    if (v < VMIN) begin
      clip_flag = 1'b1;
      return VMIN;
    end
    return v;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    return clamp_w(a + b);
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    return clamp_w(a - b);
  endfunction

  function automatic logic [63:0] mag(longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  // Apply the sign to a magnitude, clipping it to the state range
  function automatic longint sat_mag(logic [127:0] m, bit neg);
    logic [127:0] lim;
    lim = neg ? 128'(VMAX) + 128'd1 : 128'(VMAX);
    if (m > lim) begin
      clip_flag = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] prod;
    prod = {64'd0, mag(a)} * {64'd0, mag(b)};
    return sat_mag(prod >> FRAC_BITS, (a < 0) != (b < 0));
  endfunction

  // Caller guarantees den > 0
  function automatic longint fx_div(longint num, longint den);
    logic [127:0] quo;
    quo = ({64'd0, mag(num)} << FRAC_BITS) / {64'd0, 64'(den)};
    return sat_mag(quo, num < 0);
  endfunction

  function automatic void load_restart(logic [RTT_IN_W-1:0] value);
    lvl_fx   = clamp_w(longint'(64'(value)));
    drift_fx = 0;
    p_ll     = clamp_w(longint'(RESTART_COV_LEVEL) <<< FRAC_BITS);
    p_ld     = 0;
    p_dd     = clamp_w(longint'(RESTART_COV_DRIFT) <<< FRAC_BITS);
  endfunction

  function automatic tracker_out_t kalman_step(logic cmd, logic [RTT_IN_W-1:0] value);
    tracker_out_t res;
    longint meas, qr, qd, rn, pred, pp00, pp01, pp11, s, k0, k1, err, one_k0;
    clip_flag = 1'b0;
    if (cmd == CMD_RESTART) begin
      load_restart(value);
    end else begin
      meas = clamp_w(longint'(64'(value)));
      qr   = clamp_w(longint'(64'(q_rtt)));
      qd   = clamp_w(longint'(64'(q_drift)));
      rn   = clamp_w(longint'(64'(r_meas)));
      pred = sat_add(lvl_fx, drift_fx);
      pp00 = sat_add(sat_add(sat_add(p_ll, sat_add(p_ld, p_ld)), p_dd), qr);
      pp01 = sat_add(p_ld, p_dd);
      pp11 = sat_add(p_dd, qd);
      s    = sat_add(pp00, rn);
      k0   = 0;
      k1   = 0;
      // Zero gain when the innovation variance is not positive
      if (s > 0) begin
        k0 = fx_div(pp00, s);
        k1 = fx_div(pp01, s);
      end
      err      = sat_sub(meas, pred);
      lvl_fx   = sat_add(pred, fx_mul(k0, err));
      drift_fx = sat_add(drift_fx, fx_mul(k1, err));
      one_k0   = sat_sub(ONE_FX, k0);
      p_ll     = fx_mul(one_k0, pp00);
      p_ld     = fx_mul(one_k0, pp01);
      p_dd     = sat_sub(pp11, fx_mul(k1, pp01));
      // Floor the diagonal at one LSB without flagging
      if (p_ll < 1) p_ll = 1;
      if (p_dd < 1) p_dd = 1;
    end
    res.rtt_est   = lvl_fx[EST_W-1:0];
    res.drift_est = drift_fx[EST_W-1:0];
    res.rtt_var   = p_ll[VAR_W-1:0];
    res.sat       = clip_flag;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_rtt   = RTT_NOISE_RST;
      q_drift = DRIFT_NOISE_RST;
      r_meas  = MEAS_NOISE_RST;
      load_restart('0);
      estimate_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_RTT_NOISE:   q_rtt   = cfg_i.data;
          CFG_DRIFT_NOISE: q_drift = cfg_i.data;
          CFG_MEAS_NOISE:  r_meas  = cfg_i.data;
          default: ;
        endcase
      end
      // Retire the oldest estimate before queueing a new item
      if (res_i.valid && res_i.ready) begin
        if (estimate_q.size() == 0) begin
          $error("result item with no item outstanding");
          mismatches++;
        end else begin
          want = estimate_q.pop_front();
          if (res_i.rtt_estimate !== want.rtt_est) begin
            $error("rtt_estimate: expected %h, got %h", want.rtt_est, res_i.rtt_estimate);
            mismatches++;
          end
          if (res_i.drift_estimate !== want.drift_est) begin
            $error("drift_estimate: expected %h, got %h", want.drift_est,
                   res_i.drift_estimate);
            mismatches++;
          end
          if (res_i.level_var !== want.rtt_var) begin
            $error("level_var: expected %h, got %h", want.rtt_var, res_i.level_var);
            mismatches++;
          end
          if (res_i.saturated !== want.sat) begin
            $error("saturated: expected %b, got %b", want.sat, res_i.saturated);
            mismatches++;
          end
        end
      end
      if (meas_i.valid && meas_i.ready) begin
        estimate_q.push_back(kalman_step(meas_i.command, meas_i.rtt_value));
      end
      fail_count_o <= mismatches;
      pending_o    <= int'(estimate_q.size());
    end
  end

endmodule

FILE: tb/kalman_rtt_tracker_top_tb.sv
`timescale 1ns / 1ps

module kalman_rtt_tracker_top_tb import krt_pkg::*; ();

  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 240;
  localparam longint      RTT_MAX     = (longint'(1) <<< RTT_IN_W) - 1;
  localparam longint      MS          = 65536;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic clk_i;
  logic rst_ni;

  krt_cfg_if cfg_if ();
  krt_in_if  meas_if ();
  krt_out_if res_if ();

  int          fail_count;
  int          pending;
  int unsigned sent_items;
  int unsigned idle_cycles;
  bit          throttle = 1'b1;

  kalman_rtt_tracker_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .meas_i (meas_if),
    .res_o  (res_if)
  );

  kalman_rtt_tracker_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_if),
    .meas_i       (meas_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  function automatic logic [RTT_IN_W-1:0] rand_rtt();
    return RTT_IN_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [RTT_IN_W-1:0] pick_rtt();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick < 7) return RTT_IN_W'(longint'($urandom_range(1, 1000)) * MS);
    return rand_rtt();
  endfunction

  // Result side: stall at random while throttling, else stay ready
  initial begin
    int unsigned hold;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!throttle) begin
        res_if.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        hold = gap_len();
        if (hold != 0) begin
          res_if.ready <= 1'b0;
          repeat (hold) @(posedge clk_i);
        end
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: give up after a long stretch with no handshake anywhere
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((cfg_if.valid && cfg_if.ready) || (meas_if.valid && meas_if.ready) ||
          (res_if.valid && res_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("kalman_rtt_tracker_top_tb: FAIL");
    $finish;
  end

  task automatic send_item(input logic cmd, input logic [RTT_IN_W-1:0] value);
    int unsigned gap;
    meas_if.valid     <= 1'b1;
    meas_if.command   <= cmd;
    meas_if.rtt_value <= value;
    @(posedge clk_i);
    while (!meas_if.ready) @(posedge clk_i);
    sent_items++;
    gap = throttle ? gap_len() : 0;
    if (gap != 0) begin
      meas_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every outstanding item has its result
  task automatic drain();
    meas_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic apply_settings(input int unsigned ph);
    logic [CFG_DATA_W-1:0] qr, qd, rn;
    case (ph)
      0: begin qr = '0; qd = '0; rn = 32'd1; end
      1: begin qr = '1; qd = '1; rn = '1; end
      2: begin qr = RTT_NOISE_RST; qd = DRIFT_NOISE_RST; rn = MEAS_NOISE_RST; end
      3: begin qr = '0; qd = '1; rn = 32'd1; end
      4: begin qr = '1; qd = '0; rn = '1; end
      default: begin
        qr = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h00FF_FFFF);
        qd = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h00FF_FFFF);
        rn = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'hFFFF_FFFF) :
                                           $urandom_range(1, 32'h00FF_FFFF);
      end
    endcase
    write_reg(CFG_RTT_NOISE, qr);
    write_reg(CFG_DRIFT_NOISE, qd);
    write_reg(CFG_MEAS_NOISE, rn);
    write_reg(CFG_UNUSED_IDX, $urandom());
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Restart near a level, then follow it with a drifting, jittery trace
  task automatic run_track(input int unsigned n);
    logic [RTT_IN_W-1:0] base;
    longint              slope;
    longint              m;
    int unsigned         k;
    base  = pick_rtt();
    slope = longint'($urandom_range(0, 2 * MS)) - MS;
    if ($urandom_range(0, 3) == 0) slope = slope * 64;
    send_item(CMD_RESTART, base);
    for (k = 1; k <= n; k++) begin
      m = longint'(64'(base)) + slope * longint'(k) +
          longint'($urandom_range(0, 8 * MS)) - 4 * MS;
      if (m < 0) m = 0;
      if (m > RTT_MAX) m = RTT_MAX;
      if ($urandom_range(0, 19) == 0) m = longint'(64'(rand_rtt()));
      send_item(CMD_MEASURE, m[RTT_IN_W-1:0]);
    end
  endtask

  initial begin
    int unsigned ph;
    int unsigned start;
    int unsigned k;
    bit          paused;
    rst_ni            <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= '0;
    cfg_if.data       <= '0;
    meas_if.valid     <= 1'b0;
    meas_if.command   <= CMD_RESTART;
    meas_if.rtt_value <= '0;
    sent_items = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes and both commands under the reset noise values
    send_item(CMD_MEASURE, '0);
    send_item(CMD_MEASURE, '1);
    send_item(CMD_RESTART, '0);
    send_item(CMD_MEASURE, '0);
    send_item(CMD_MEASURE, '0);
    send_item(CMD_RESTART, '1);
    send_item(CMD_MEASURE, '1);
    send_item(CMD_MEASURE, '0);
    send_item(CMD_MEASURE, '1);
    send_item(CMD_RESTART, RTT_IN_W'(100 * MS));
    for (k = 1; k <= 6; k++) begin
      send_item(CMD_MEASURE, RTT_IN_W'((100 + 3 * longint'(k)) * MS));
    end
    send_item(CMD_RESTART, '0);
    send_item(CMD_MEASURE, '1);
    send_item(CMD_MEASURE, 36'hA_AAAA_AAAA);
    send_item(CMD_MEASURE, 36'h5_5555_5555);
    send_item(CMD_RESTART, rand_rtt());
    send_item(CMD_MEASURE, rand_rtt());

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      apply_settings(ph);
      start  = sent_items;
      paused = 1'b0;
      while (sent_items - start < PHASE_ITEMS) begin
        if (!paused && (sent_items - start >= PHASE_ITEMS / 2)) begin
          drain();
          paused = 1'b1;
        end
        throttle <= ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 4) == 0) begin
          send_item(logic'($urandom_range(0, 1)), rand_rtt());
        end else begin
          run_track($urandom_range(1, 30));
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("kalman_rtt_tracker_top_tb: PASS");
    end else begin
      $display("kalman_rtt_tracker_top_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/krt_pkg.sv
hw/rtl/krt_if.sv
hw/rtl/krt_mul.sv
hw/rtl/krt_div.sv
hw/rtl/kalman_rtt_tracker_top.sv
tb/kalman_rtt_tracker_checker.sv
tb/kalman_rtt_tracker_top_tb.sv
